// ===== hw/rtl/mrhm_pkg.sv =====
// mrhm_pkg: shared types, codes and the crc-16 step of the read-holding master
// used by mrhm_stream_if users, mrhm_engine and the top level
`timescale 1ns / 1ps

package mrhm_pkg;

    // protocol constants
    localparam logic [7:0]  FUNC_READ   = 8'd3;
    localparam logic [7:0]  MAX_SLAVE   = 8'd247;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [16:0] ADDR_SPACE  = 17'h10000;
    localparam int          FRAME_BYTES = 8;
    localparam int          CRC_BYTE_LO = FRAME_BYTES - 2;

    // configuration port
    localparam int          CFG_IDX_W   = 1;
    localparam int          CFG_DATA_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QTY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_CAP = 1'd1;
    localparam logic [6:0]  MAX_QTY_RST = 7'd125;
    localparam logic [7:0]  REG_CAP_RST = 8'd125;

    typedef enum logic [1:0] {
        KIND_FRAME  = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_REQ    = 3'd1,
        ST_SLAVE      = 3'd2,
        ST_FUNC       = 3'd3,
        ST_BYTE_COUNT = 3'd4,
        ST_TRUNC      = 3'd5,
        ST_CAPACITY   = 3'd6,
        ST_CRC        = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_CRC    = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic        mode;
        logic [7:0]  slave_addr;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [7:0]  rx_byte;
        logic        frame_end;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] out_data;
        logic [6:0]  reg_index;
        t_status     status;
        logic        last;
    } t_result;

    // what one item produces: a request frame or up to two plain results
    typedef struct packed {
        logic        is_req;
        logic [1:0]  count;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [15:0] qty;
        t_result     r0;
        t_result     r1;
    } t_res_set;

    // one byte of crc-16/modbus, reflected
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mrhm_stream_if.sv =====
// mrhm_stream_if: valid/ready channel carrying one packed payload
// payload types come from mrhm_pkg at the instantiation
`timescale 1ns / 1ps

interface mrhm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mrhm_engine.sv =====
// mrhm_engine: request check and response byte parser with frame state
// depends on mrhm_pkg (types, codes, crc_update)
`timescale 1ns / 1ps

module mrhm_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrhm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_take,
    input  mrhm_pkg::t_in_item              i_item,
    output mrhm_pkg::t_res_set              o_res
);
    import mrhm_pkg::*;

    logic [6:0]  r_max_qty;
    logic [7:0]  r_reg_cap;
    logic [7:0]  r_exp_slave, n_exp_slave;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_byte_total, n_byte_total;
    logic [7:0]  r_high_hold, n_high_hold;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;
    t_phase      r_phase, n_phase;

    logic [15:0] crc_next;
    logic [16:0] end_addr;
    logic        req_bad;
    t_status     hdr_err;
    logic [7:0]  pos_inc;
    logic        data_done;
    logic        prim;
    t_result     prim_res;
    logic        closed_pre;
    logic        trunc;
    logic [6:0]  trunc_cnt;
    logic        go_header;
    logic        go_skip;
    t_result     trunc_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_qty <= MAX_QTY_RST;
            r_reg_cap <= REG_CAP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_QTY) begin
                r_max_qty <= i_cfg_data[6:0];
            end else if (i_cfg_index == CFG_REG_CAP) begin
                r_reg_cap <= i_cfg_data;
            end
        end
    end

    // decode of the current item against frame state
    always_comb begin
        crc_next  = crc_update(r_crc, i_item.rx_byte);
        end_addr  = {1'b0, i_item.start_address} + {1'b0, i_item.quantity};
        req_bad   = (i_item.quantity == 16'd0) || (i_item.quantity > {9'd0, r_max_qty}) ||
                    (i_item.slave_addr == 8'd0) || (i_item.slave_addr > MAX_SLAVE) ||
                    (end_addr > ADDR_SPACE);
        pos_inc   = r_pos + 8'd1;
        data_done = (pos_inc >= r_byte_total);

        // header byte checks
        hdr_err = ST_OK;
        case (r_pos)
            8'd0: begin
                if (i_item.rx_byte != r_exp_slave) hdr_err = ST_SLAVE;
            end
            8'd1: begin
                if (i_item.rx_byte != FUNC_READ) hdr_err = ST_FUNC;
            end
            default: begin
                if ((i_item.rx_byte == 8'd0) || i_item.rx_byte[0] ||
                    (i_item.rx_byte > {r_max_qty, 1'b0})) begin
                    hdr_err = ST_BYTE_COUNT;
                end else if ({1'b0, i_item.rx_byte[7:1]} > r_reg_cap) begin
                    hdr_err = ST_CAPACITY;
                end
            end
        endcase

        // first result of a response byte
        prim       = 1'b0;
        closed_pre = 1'b0;
        prim_res   = '{kind: KIND_STATUS, out_data: 16'd0, reg_index: 7'd0,
                       status: ST_OK, last: 1'b1};
        trunc_cnt  = 7'd0;
        case (r_phase)
            PH_HEADER: begin
                if (hdr_err != ST_OK) begin
                    prim            = 1'b1;
                    closed_pre      = 1'b1;
                    prim_res.status = hdr_err;
                end
            end
            PH_DATA: begin
                if (r_pos[0]) begin
                    prim               = 1'b1;
                    prim_res.kind      = KIND_WORD;
                    prim_res.out_data  = {r_high_hold, i_item.rx_byte};
                    prim_res.reg_index = r_pos[7:1];
                end
                trunc_cnt = data_done ? r_byte_total[7:1] : pos_inc[7:1];
            end
            PH_CRC: begin
                trunc_cnt = r_byte_total[7:1];
                if (r_pos != 8'd0) begin
                    prim              = 1'b1;
                    closed_pre        = 1'b1;
                    prim_res.out_data = {9'd0, r_byte_total[7:1]};
                    prim_res.status   = ({i_item.rx_byte, r_crc_low} == r_crc) ? ST_OK : ST_CRC;
                end
            end
            default: begin
            end
        endcase

        trunc     = (r_phase != PH_SKIP) && !closed_pre && i_item.frame_end;
        trunc_res = '{kind: KIND_STATUS, out_data: {9'd0, trunc_cnt}, reg_index: 7'd0,
                      status: ST_TRUNC, last: 1'b1};

        go_header = (!i_item.mode && !req_bad) ||
                    (i_item.mode && i_item.frame_end &&
                     ((r_phase == PH_SKIP) || closed_pre || trunc));
        go_skip   = i_item.mode && closed_pre && !i_item.frame_end;
    end

    // next frame state
    always_comb begin
        n_exp_slave  = r_exp_slave;
        n_pos        = r_pos;
        n_byte_total = r_byte_total;
        n_high_hold  = r_high_hold;
        n_crc        = r_crc;
        n_crc_low    = r_crc_low;
        n_phase      = r_phase;
        if (i_take) begin
            if (!i_item.mode) begin
                if (!req_bad) n_exp_slave = i_item.slave_addr;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_crc = crc_next;
                        if (hdr_err == ST_OK) begin
                            case (r_pos)
                                8'd0: n_pos = 8'd1;
                                8'd1: n_pos = 8'd2;
                                default: begin
                                    n_byte_total = i_item.rx_byte;
                                    n_pos        = 8'd0;
                                    n_phase      = PH_DATA;
                                end
                            endcase
                        end
                    end
                    PH_DATA: begin
                        n_crc = crc_next;
                        if (!r_pos[0]) n_high_hold = i_item.rx_byte;
                        if (data_done) begin
                            n_pos   = 8'd0;
                            n_phase = PH_CRC;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_CRC: begin
                        if (r_pos == 8'd0) begin
                            n_crc_low = i_item.rx_byte;
                            n_pos     = 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // frame close or new request
            if (go_header) begin
                n_phase      = PH_HEADER;
                n_pos        = 8'd0;
                n_byte_total = 8'd0;
                n_high_hold  = 8'd0;
                n_crc        = CRC_INIT;
                n_crc_low    = 8'd0;
            end else if (go_skip) begin
                n_phase = PH_SKIP;
            end
        end
    end

    // results of the current item
    always_comb begin
        o_res        = '0;
        o_res.slave  = i_item.slave_addr;
        o_res.addr   = i_item.start_address;
        o_res.qty    = i_item.quantity;
        o_res.r1     = trunc_res;
        if (!i_item.mode) begin
            if (req_bad) begin
                o_res.count = 2'd1;
                o_res.r0    = '{kind: KIND_STATUS, out_data: 16'd0, reg_index: 7'd0,
                                status: ST_BAD_REQ, last: 1'b1};
            end else begin
                o_res.is_req = 1'b1;
            end
        end else if (r_phase != PH_SKIP) begin
            o_res.count = {1'b0, prim} + {1'b0, trunc};
            o_res.r0    = prim ? prim_res : trunc_res;
            o_res.r0.last = !(prim && trunc);
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_slave  <= 8'd0;
            r_pos        <= 8'd0;
            r_byte_total <= 8'd0;
            r_high_hold  <= 8'd0;
            r_crc        <= CRC_INIT;
            r_crc_low    <= 8'd0;
            r_phase      <= PH_HEADER;
        end else begin
            r_exp_slave  <= n_exp_slave;
            r_pos        <= n_pos;
            r_byte_total <= n_byte_total;
            r_high_hold  <= n_high_hold;
            r_crc        <= n_crc;
            r_crc_low    <= n_crc_low;
            r_phase      <= n_phase;
        end
    end

    // data and crc phases only ever seen with an even, nonzero byte total
    a_total_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_CRC) |-> (!r_byte_total[0] && r_byte_total != 8'd0))
        else $error("byte total odd or zero outside header phase");
    a_data_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_pos < r_byte_total))
        else $error("data position ran past byte total");
    a_crc_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRC) |-> (r_pos <= 8'd1))
        else $error("crc position out of range");

endmodule

// ===== hw/rtl/modbus_rtu_read_holding_master_unit.sv =====
// modbus_rtu_read_holding_master_unit: top level, input register and result emitter
// depends on mrhm_pkg, mrhm_stream_if and mrhm_engine
`timescale 1ns / 1ps

// Usage:
//  i_item (sink) takes one item per transfer: mode 0 is a read request
//  (slave_addr, start_address, quantity), mode 1 is one received response
//  byte (rx_byte, frame_end). o_result (source) gives the result items,
//  with last set on the final result of each item.
//  Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//  (0 max_quantity, 1 reg_capacity); write only while the block is idle.
//  The first result of an item is registered: the item sits in the
//  input register, then loads the result register when the results of
//  the previous item are done. A valid request streams eight frame
//  bytes, one per cycle while o_result.ready is high; the crc is built
//  byte by byte as the frame goes out. Any other item gives its results
//  one by one, or none; the next item waits in the input register and
//  moves up in the cycle the previous item's last result transfers.
//  Stall: with o_result.ready low the current result holds and one more
//  item is still taken into the input register; after that i_item.ready
//  stays low. Reset clears both registers and the frame state, and sets
//  max_quantity and reg_capacity to 125.
module modbus_rtu_read_holding_master_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrhm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mrhm_stream_if.sink                     i_item,
    mrhm_stream_if.source                   o_result
);
    import mrhm_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    t_res_set    res;

    logic        r_busy;
    logic        r_is_req;
    logic        r_two;
    logic [2:0]  r_pos;
    t_result     r_res0;
    t_result     r_res1;
    logic [7:0]  r_slave;
    logic [15:0] r_addr;
    logic [15:0] r_qty;
    logic [15:0] r_crc;

    t_result     cur;
    logic [7:0]  req_byte;
    logic        in_xfer;
    logic        out_xfer;
    logic        load;

    mrhm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (load),
        .i_item      (r_in_item),
        .o_res       (res)
    );

    // request frame byte at the current position
    always_comb begin
        case (r_pos)
            3'd0:    req_byte = r_slave;
            3'd1:    req_byte = FUNC_READ;
            3'd2:    req_byte = r_addr[15:8];
            3'd3:    req_byte = r_addr[7:0];
            3'd4:    req_byte = r_qty[15:8];
            3'd5:    req_byte = r_qty[7:0];
            3'd6:    req_byte = r_crc[7:0];
            3'd7:    req_byte = r_crc[15:8];
            default: req_byte = 8'd0;
        endcase
    end

    // current result
    always_comb begin
        if (r_is_req) begin
            cur = '{kind: KIND_FRAME, out_data: {8'd0, req_byte}, reg_index: 7'd0,
                    status: ST_OK, last: (r_pos == 3'(FRAME_BYTES - 1))};
        end else begin
            cur = (r_pos[0] && r_two) ? r_res1 : r_res0;
        end
    end

    // handshakes
    assign out_xfer         = r_busy && o_result.ready;
    assign load             = r_in_valid && (!r_busy || (out_xfer && cur.last));
    assign i_item.ready     = !r_in_valid || load;
    assign in_xfer          = i_item.valid && i_item.ready;
    assign o_result.valid   = r_busy;
    assign o_result.payload = cur;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_item.payload;
        end
    end

    // emitter control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_is_req <= 1'b0;
            r_two    <= 1'b0;
            r_pos    <= 3'd0;
        end else if (load) begin
            r_busy   <= res.is_req || (res.count != 2'd0);
            r_is_req <= res.is_req;
            r_two    <= (res.count == 2'd2);
            r_pos    <= 3'd0;
        end else if (out_xfer) begin
            if (cur.last) r_busy <= 1'b0;
            r_pos <= r_pos + 3'd1;
        end
    end

    // emitter payload and running frame crc
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res0  <= res.r0;
            r_res1  <= res.r1;
            r_slave <= res.slave;
            r_addr  <= res.addr;
            r_qty   <= res.qty;
            r_crc   <= CRC_INIT;
        end else if (out_xfer && r_is_req && (r_pos < 3'(CRC_BYTE_LO))) begin
            r_crc <= crc_update(r_crc, req_byte);
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_result.ready) |=> (r_busy && $stable(r_pos)))
        else $error("pending result lost during stall");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !load) |=> (r_in_valid && $stable(r_in_item)))
        else $error("waiting input item overwritten");
    a_status_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.payload.kind == KIND_STATUS)) |->
        (o_result.payload.reg_index == 7'd0))
        else $error("status result with nonzero register index");
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_is_req && (r_pos == 3'(FRAME_BYTES - 1)) && !load) |=> !r_busy)
        else $error("emitter still busy after last frame byte");
    a_func_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_is_req && (r_pos == 3'd1)) |->
        (o_result.payload.out_data == {8'd0, FUNC_READ}))
        else $error("request frame without read function code");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for modbus_rtu_read_holding_master_unit
// drives request and response-byte transfers, predicts frames, words and statuses
// depends on mrhm_pkg, mrhm_stream_if and the top level rtl
`timescale 1ns / 1ps

module tb_top;
    import mrhm_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mrhm_stream_if #(.t_payload(t_in_item)) item_if ();
    mrhm_stream_if #(.t_payload(t_result))  res_if ();

    modbus_rtu_read_holding_master_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_if),
        .o_result    (res_if)
    );

    // mirror of the master: request builder, response parser, awaited results
    class rtu_master_board;
        logic [6:0]  max_qty;
        logic [7:0]  reg_cap;
        logic [7:0]  slave_hold;
        logic [7:0]  rx_pos;
        logic [7:0]  byte_total;
        logic [7:0]  high_byte;
        logic [7:0]  crc_low_byte;
        logic [15:0] crc_acc;
        t_phase      phase;
        t_result     pending_results[$];
        int          errors;
        int          live_items;
        int          results_seen;
        int          frame_bytes;
        int          words;
        int          status_tally[8];

        function new();
            max_qty      = MAX_QTY_RST;
            reg_cap      = REG_CAP_RST;
            slave_hold   = 8'd0;
            errors       = 0;
            live_items   = 0;
            results_seen = 0;
            frame_bytes  = 0;
            words        = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
            restart_rx();
        endfunction

        // bit-serial crc-16/modbus, lsb first
        static function logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] data);
            logic [15:0] r;
            logic        fb;
            r = acc;
            for (int n = 0; n < 8; n++) begin
                fb = r[0] ^ data[n];
                r  = r >> 1;
                if (fb) begin
                    r = r ^ CRC_POLY;
                end
            end
            return r;
        endfunction

        function void restart_rx();
            phase        = PH_HEADER;
            rx_pos       = 8'd0;
            byte_total   = 8'd0;
            high_byte    = 8'd0;
            crc_acc      = CRC_INIT;
            crc_low_byte = 8'd0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MAX_QTY) begin
                max_qty = data[6:0];
            end else if (idx == CFG_REG_CAP) begin
                reg_cap = data;
            end
        endfunction

        function void queue_result(t_kind kind, logic [15:0] data, logic [6:0] idx,
                                   t_status st);
            t_result r;
            r.kind      = kind;
            r.out_data  = data;
            r.reg_index = idx;
            r.status    = st;
            r.last      = 1'b0;
            pending_results.push_back(r);
        endfunction

        // work out what one accepted transfer must produce
        function void predict_item(t_in_item it);
            logic [7:0]  fr[8];
            logic [15:0] acc;
            logic [15:0] recv;
            logic [15:0] cnt;
            logic [7:0]  b;
            t_status     err;
            bit          closed;
            int          queued_at;
            queued_at = pending_results.size();
            closed    = 1'b0;
            err       = ST_OK;
            if (it.mode == 1'b0) begin
                live_items++;
                if (it.quantity == 16'd0 || it.quantity > {9'd0, max_qty} ||
                    it.slave_addr == 8'd0 || it.slave_addr > MAX_SLAVE ||
                    ({1'b0, it.start_address} + {1'b0, it.quantity}) > ADDR_SPACE) begin
                    queue_result(KIND_STATUS, 16'd0, 7'd0, ST_BAD_REQ);
                end else begin
                    fr[0] = it.slave_addr;
                    fr[1] = FUNC_READ;
                    fr[2] = it.start_address[15:8];
                    fr[3] = it.start_address[7:0];
                    fr[4] = it.quantity[15:8];
                    fr[5] = it.quantity[7:0];
                    acc = CRC_INIT;
                    for (int i = 0; i < 6; i++) acc = crc16_step(acc, fr[i]);
                    fr[6] = acc[7:0];
                    fr[7] = acc[15:8];
                    for (int i = 0; i < 8; i++) begin
                        queue_result(KIND_FRAME, {8'd0, fr[i]}, 7'd0, ST_OK);
                    end
                    slave_hold = it.slave_addr;
                    restart_rx();
                end
            end else if (phase == PH_SKIP) begin
                // dropped until the frame closes
                if (it.frame_end) begin
                    restart_rx();
                end
            end else begin
                live_items++;
                b = it.rx_byte;
                case (phase)
                    PH_HEADER: begin
                        crc_acc = crc16_step(crc_acc, b);
                        if (rx_pos == 8'd0) begin
                            if (b != slave_hold) err = ST_SLAVE;
                            else rx_pos = 8'd1;
                        end else if (rx_pos == 8'd1) begin
                            if (b != FUNC_READ) err = ST_FUNC;
                            else rx_pos = 8'd2;
                        end else if (b == 8'd0 || b[0] || b > {max_qty, 1'b0}) begin
                            err = ST_BYTE_COUNT;
                        end else if ({1'b0, b[7:1]} > reg_cap) begin
                            err = ST_CAPACITY;
                        end else begin
                            byte_total = b;
                            rx_pos     = 8'd0;
                            phase      = PH_DATA;
                        end
                        if (err != ST_OK) begin
                            queue_result(KIND_STATUS, 16'd0, 7'd0, err);
                            closed = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        crc_acc = crc16_step(crc_acc, b);
                        if (!rx_pos[0]) begin
                            high_byte = b;
                        end else begin
                            queue_result(KIND_WORD, {high_byte, b}, rx_pos[7:1], ST_OK);
                        end
                        rx_pos = rx_pos + 8'd1;
                        if (rx_pos >= byte_total) begin
                            phase  = PH_CRC;
                            rx_pos = 8'd0;
                        end
                    end
                    default: begin
                        if (rx_pos == 8'd0) begin
                            crc_low_byte = b;
                            rx_pos       = 8'd1;
                        end else begin
                            recv = {b, crc_low_byte};
                            queue_result(KIND_STATUS, {9'd0, byte_total[7:1]}, 7'd0,
                                         (recv == crc_acc) ? ST_OK : ST_CRC);
                            closed = 1'b1;
                        end
                    end
                endcase
                // frame closed early by the line
                if (!closed && it.frame_end) begin
                    cnt = 16'd0;
                    if (phase == PH_DATA) cnt = {9'd0, rx_pos[7:1]};
                    else if (phase == PH_CRC) cnt = {9'd0, byte_total[7:1]};
                    queue_result(KIND_STATUS, cnt, 7'd0, ST_TRUNC);
                    closed = 1'b1;
                end
                if (closed) begin
                    if (it.frame_end) restart_rx();
                    else phase = PH_SKIP;
                end
            end
            if (pending_results.size() > queued_at) begin
                pending_results[pending_results.size() - 1].last = 1'b1;
            end
        endfunction

        function void field_match(string name, int want_v, int got_v);
            if (want_v != got_v) begin
                errors++;
                $display("%0t mismatch in %s: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        // compare one result transfer with the oldest awaited one
        function void check_result(t_result got);
            t_result want;
            results_seen++;
            case (got.kind)
                KIND_FRAME:  frame_bytes++;
                KIND_WORD:   words++;
                KIND_STATUS: status_tally[got.status]++;
                default: ;
            endcase
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: kind %0d data %0d status %0d",
                         $time, got.kind, got.out_data, got.status);
                return;
            end
            want = pending_results.pop_front();
            field_match("kind", want.kind, got.kind);
            field_match("out_data", want.out_data, got.out_data);
            field_match("reg_index", want.reg_index, got.reg_index);
            field_match("status", want.status, got.status);
            field_match("last", want.last, got.last);
        endfunction
    endclass

    rtu_master_board board;
    int              burst_left;
    int              hold_left;
    bit              hold_kick;
    int              stretch_left;
    int              stretch_mode;
    int              cycle_count;
    int              sent_items;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, board.pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // observe both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) board.predict_item(item_if.payload);
            if (res_if.valid && res_if.ready) board.check_result(res_if.payload);
        end
    end

    // result sink: stretches of no, light and heavy stalls, plus a long hold-off
    initial begin
        res_if.ready = 1'b0;
        hold_left    = 0;
        hold_kick    = 1'b0;
        stretch_left = 0;
        stretch_mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_kick) begin
                hold_kick = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(10, 80);
                end
                stretch_left--;
                case (stretch_mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 9) < 7);
                    default: res_if.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    function automatic t_in_item scrambled_item();
        t_in_item it;
        it.mode          = 1'($urandom);
        it.slave_addr    = 8'($urandom);
        it.start_address = 16'($urandom);
        it.quantity      = 16'($urandom);
        it.rx_byte       = 8'($urandom);
        it.frame_end     = 1'($urandom);
        return it;
    endfunction

    // mostly short reads so that frames stay a few dozen bytes at most
    function automatic logic [15:0] pick_quantity();
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = board.max_qty;
        if (roll < 80) return 16'($urandom_range(1, (top < 4) ? top : 4));
        if (roll < 95) return 16'($urandom_range(1, (top < 12) ? top : 12));
        return 16'((top < 16) ? top : 16);
    endfunction

    // one transfer on the item channel; starts and ends at a falling edge
    task automatic send_item(input t_in_item it);
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    // sender bursts with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_request(input logic [7:0] sl, input logic [15:0] ad,
                                input logic [15:0] q);
        t_in_item it;
        it               = scrambled_item();
        it.mode          = 1'b0;
        it.slave_addr    = sl;
        it.start_address = ad;
        it.quantity      = q;
        send_item(it);
        pace();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fe);
        t_in_item it;
        it           = scrambled_item();
        it.mode      = 1'b1;
        it.rx_byte   = b;
        it.frame_end = fe;
        send_item(it);
        pace();
    endtask

    // response frame: header, data, crc; optional cut, crc damage, late close
    task automatic send_frame(input logic [7:0] sl, input logic [7:0] fn,
                              input logic [7:0] bc, input int n_data, input int cut,
                              input bit bad_crc, input bit late_close);
        logic [7:0]  octets[$];
        logic [15:0] acc;
        int          junk;
        octets = {sl, fn, bc};
        for (int i = 0; i < n_data; i++) octets.push_back(8'($urandom));
        acc = CRC_INIT;
        foreach (octets[i]) acc = rtu_master_board::crc16_step(acc, octets[i]);
        if (bad_crc) acc = acc ^ 16'($urandom_range(1, 65535));
        octets.push_back(acc[7:0]);
        octets.push_back(acc[15:8]);
        if (cut >= 0) begin
            late_close = 1'b0;
            while (octets.size() > cut + 1) void'(octets.pop_back());
        end
        foreach (octets[i]) send_byte(octets[i], (i == octets.size() - 1) && !late_close);
        if (late_close) begin
            junk = $urandom_range(0, 2);
            repeat (junk) send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b1);
        end
    endtask

    // request then a response, mostly clean, sometimes damaged
    task automatic random_transaction(input bit fresh);
        logic [15:0] q;
        logic [15:0] ad;
        logic [7:0]  sl;
        logic [7:0]  bc;
        int          roll;
        int          n_data;
        int          top2;
        q = pick_quantity();
        if (fresh) begin
            sl = 8'($urandom_range(1, 247));
            ad = 16'($urandom_range(0, 65536 - q));
            send_request(sl, ad, q);
        end else begin
            sl = board.slave_hold;
        end
        bc     = 8'(2 * q);
        n_data = 2 * q;
        top2   = 2 * board.max_qty;
        roll   = $urandom_range(0, 99);
        if (roll < 55) begin
            send_frame(sl, FUNC_READ, bc, n_data, -1, 1'b0, $urandom_range(0, 4) == 0);
        end else if (roll < 63) begin
            send_frame(sl, FUNC_READ, bc, n_data, -1, 1'b1, $urandom_range(0, 3) == 0);
        end else if (roll < 73) begin
            send_frame(sl, FUNC_READ, bc, n_data, $urandom_range(0, n_data + 3), 1'b0, 1'b0);
        end else if (roll < 78) begin
            send_frame(sl ^ 8'($urandom_range(1, 255)), FUNC_READ, bc, n_data, -1, 1'b0,
                       $urandom_range(0, 1));
        end else if (roll < 83) begin
            send_frame(sl, FUNC_READ ^ 8'($urandom_range(1, 255)), bc, n_data, -1, 1'b0,
                       $urandom_range(0, 1));
        end else if (roll < 90) begin
            case ($urandom_range(0, 2))
                0:       bc = 8'd0;
                1:       bc = 8'($urandom_range(0, 127) * 2 + 1);
                default: bc = 8'($urandom_range(top2 + 1, 255));
            endcase
            send_frame(sl, FUNC_READ, bc, $urandom_range(0, 6), -1, 1'b0, $urandom_range(0, 1));
        end else begin
            // byte count unrelated to the request, reaches the capacity check
            bc = 8'($urandom_range(1, (top2 / 2 < 12) ? top2 / 2 : 12) * 2);
            send_frame(sl, FUNC_READ, bc, bc, -1, 1'b0, 1'b0);
        end
    endtask

    // requests that probe the validation bounds
    task automatic edge_request();
        logic [15:0] q;
        logic [15:0] ad;
        logic [7:0]  sl;
        q  = 16'($urandom);
        ad = 16'($urandom);
        sl = 8'($urandom_range(1, 247));
        case ($urandom_range(0, 3))
            0: sl = 8'($urandom);
            1: begin
                q  = pick_quantity();
                ad = 16'(65536 - q);
            end
            2: q = {9'd0, board.max_qty} + 16'($urandom_range(1, 3));
            default: begin
                q  = pick_quantity();
                sl = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(248, 255));
            end
        endcase
        send_request(sl, ad, q);
    endtask

    task automatic line_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // stop offering and wait for every awaited result, then let the pipe settle
    task automatic drain();
        item_if.valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic directed_checks();
        // wrong slave, then bytes dropped up to the closing one
        send_byte(8'd5, 1'b0);
        send_byte(8'($urandom), 1'b1);
        // before any request only slave address zero matches
        send_frame(8'd0, FUNC_READ, 8'd2, 2, -1, 1'b0, 1'b0);
        // request bounds
        send_request(8'd0, 16'd0, 16'd1);
        send_request(8'd255, 16'hFFFF, 16'hFFFF);
        send_request(8'd1, 16'd0, 16'd0);
        send_request(8'd1, 16'hFFFF, 16'd2);
        send_request(MAX_SLAVE, 16'hFFFF, 16'd1);
        // wrong function code on the closing byte
        send_byte(MAX_SLAVE, 1'b0);
        send_byte(8'h04, 1'b1);
        // zero byte count
        send_byte(MAX_SLAVE, 1'b0);
        send_byte(FUNC_READ, 1'b0);
        send_byte(8'd0, 1'b1);
        // frame cut inside the data
        send_byte(MAX_SLAVE, 1'b0);
        send_byte(FUNC_READ, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'h12, 1'b1);
    endtask

    task automatic run_phase(input logic [6:0] mq, input logic [7:0] cap, input int count,
                             input bit long_hold, input bit mid_pause);
        int start;
        int roll;
        bit paused;
        drain();
        write_reg(CFG_MAX_QTY, {1'b0, mq});
        write_reg(CFG_REG_CAP, cap);
        if (long_hold) hold_kick = 1'b1;
        start  = sent_items;
        paused = 1'b0;
        while (sent_items - start < count) begin
            if (mid_pause && !paused && (sent_items - start >= count / 2)) begin
                drain();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 60) random_transaction(1'b1);
            else if (roll < 70) random_transaction(1'b0);
            else if (roll < 85) edge_request();
            else line_noise();
        end
    endtask

    // main sequence
    initial begin
        board           = new();
        burst_left      = 0;
        sent_items      = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_checks();
        run_phase(7'd125, 8'd255, 50, 1'b1, 1'b0);
        run_phase(7'd1, 8'd0, 40, 1'b0, 1'b0);
        run_phase(7'd7, 8'd3, 50, 1'b0, 1'b1);
        run_phase(7'd125, 8'd125, 50, 1'b0, 1'b0);
        run_phase(7'($urandom_range(1, 125)), 8'($urandom), 30, 1'b0, 1'b0);
        drain();

        $display("covered %0d items sent (%0d live), %0d results: %0d frame bytes, %0d words",
                 sent_items, board.live_items, board.results_seen, board.frame_bytes,
                 board.words);
        $display("statuses ok %0d badreq %0d slave %0d func %0d count %0d trunc %0d cap %0d crc %0d",
                 board.status_tally[ST_OK], board.status_tally[ST_BAD_REQ],
                 board.status_tally[ST_SLAVE], board.status_tally[ST_FUNC],
                 board.status_tally[ST_BYTE_COUNT], board.status_tally[ST_TRUNC],
                 board.status_tally[ST_CAPACITY], board.status_tally[ST_CRC]);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
